// File: hdl/rc5_pkg.sv
`default_nettype none

package rc5_pkg;

   // Default build sizes.
   localparam int unsigned DEF_MAX_ROUNDS    = 32;
   localparam int unsigned DEF_MAX_KEY_BYTES = 32;

   // Fixed field widths.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BLOCK_W  = 64;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned CFG_W    = 6;
   localparam int unsigned KEY_BITS = 256;
   localparam int unsigned CSR_AW   = 6;
   localparam int unsigned CSR_DW   = 64;

   // Magic constants of the RC5-32 key schedule.
   localparam logic [WORD_W-1:0] P32 = 32'hB7E1_5163;
   localparam logic [WORD_W-1:0] Q32 = 32'h9E37_79B9;
   localparam logic [4:0]        ROT_MASK = 5'd31;
   localparam logic [4:0]        ROT_MIX  = 5'd3;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_KEY0   = 3'd0;
   localparam logic [2:0] REG_KEY1   = 3'd1;
   localparam logic [2:0] REG_KEY2   = 3'd2;
   localparam logic [2:0] REG_KEY3   = 3'd3;
   localparam logic [2:0] REG_KEYLEN = 3'd4;
   localparam logic [2:0] REG_ROUNDS = 3'd5;

   typedef enum logic [1:0] {
      MODE_EXPAND  = 2'd0,
      MODE_ENCRYPT = 2'd1,
      MODE_DECRYPT = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RES_ZERO   = 2'd0,
      RES_ERROR  = 2'd1,
      RES_CIPHER = 2'd2
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       expand_start;
      logic       cipher_start;
      logic       init_write;
      logic       mix_a;
      logic       mix_b;
      logic       cipher_step;
      logic       step_b;
      logic       step_white;
      logic       step_decrypt;
      logic       out_load;
      result_type out_kind;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   // Rotate left by a 5-bit amount.
   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                input logic [4:0] n);
      logic [2*WORD_W-1:0] d;
      d = {x, x} << (n & ROT_MASK);
      return d[2*WORD_W-1:WORD_W];
   endfunction

   // Rotate right by a 5-bit amount.
   function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                input logic [4:0] n);
      logic [2*WORD_W-1:0] d;
      d = {x, x} >> (n & ROT_MASK);
      return d[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/rc5_ram.sv
`default_nettype none

module rc5_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 66
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/rc5_datapath.sv
`default_nettype none

module rc5_datapath #(
   parameter int unsigned MAX_KEY_BYTES = 32,
   parameter int unsigned KW_AW         = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rc5_pkg::ctrl_cmd_type           cmd,
   output rc5_pkg::dp_status_type               status,
   input  wire logic [KW_AW-1:0]                key_idx,
   input  wire logic [rc5_pkg::KEY_BITS-1:0]    key_bits,
   input  wire logic [rc5_pkg::CFG_W-1:0]       key_length,
   input  wire logic [rc5_pkg::BLOCK_W-1:0]     block_in,
   input  wire logic [rc5_pkg::WORD_W-1:0]      rd_data,
   output logic      [rc5_pkg::WORD_W-1:0]      wr_data,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [rc5_pkg::BLOCK_W-1:0]     rsp_tdata,
   output logic      [0:0]                      rsp_tuser
);

   import rc5_pkg::*;

   localparam int unsigned KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;

   logic [WORD_W-1:0]  a_ff, a_in;
   logic [WORD_W-1:0]  b_ff, b_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0]  kw_ff [KEY_WORDS];
   logic [WORD_W-1:0]  kw_in [KEY_WORDS];
   logic [BLOCK_W-1:0] out_block_ff, out_block_in;
   logic               out_status_ff, out_status_in;
   logic               out_valid_ff, out_valid_in;

   logic [WORD_W-1:0] a_mix;
   logic [WORD_W-1:0] ab_sum;
   logic [WORD_W-1:0] b_mix;
   logic [WORD_W-1:0] x_word;
   logic [WORD_W-1:0] y_word;
   logic [WORD_W-1:0] x_new;

   // Key mixing: the subkey half and then the key word half of one step.
   always_comb begin
      a_mix  = rotl32(rd_data + a_ff + b_ff, ROT_MIX);
      ab_sum = a_ff + b_ff;
      b_mix  = rotl32(kw_ff[key_idx] + ab_sum, ab_sum[4:0]);
   end

   // Memory write data: the arithmetic fill first, then mixed subkeys.
   assign wr_data = cmd.init_write ? acc_ff : a_mix;

   // One cipher half-round on the word selected by the subkey index parity.
   always_comb begin
      x_word = cmd.step_b ? b_ff : a_ff;
      y_word = cmd.step_b ? a_ff : b_ff;
      if (cmd.step_decrypt) begin
         if (cmd.step_white) begin
            x_new = x_word - rd_data;
         end else begin
            x_new = rotr32(x_word - rd_data, y_word[4:0]) ^ y_word;
         end
      end else begin
         if (cmd.step_white) begin
            x_new = x_word + rd_data;
         end else begin
            x_new = rotl32(x_word ^ y_word, y_word[4:0]) + rd_data;
         end
      end
   end

   // Working words and the fill accumulator.
   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (cmd.expand_start) begin
         a_in   = '0;
         b_in   = '0;
         acc_in = P32;
      end
      if (cmd.init_write) begin
         acc_in = acc_ff + Q32;
      end
      if (cmd.cipher_start) begin
         a_in = block_in[WORD_W-1:0];
         b_in = block_in[BLOCK_W-1:WORD_W];
      end
      if (cmd.mix_a) begin
         a_in = a_mix;
      end
      if (cmd.mix_b) begin
         b_in = b_mix;
      end
      if (cmd.cipher_step) begin
         if (cmd.step_b) begin
            b_in = x_new;
         end else begin
            a_in = x_new;
         end
      end
   end

   // Key words: packed from the key bytes in use, then rewritten by mixing.
   always_comb begin
      for (int w = 0; w < KEY_WORDS; w++) begin
         kw_in[w] = kw_ff[w];
         if (cmd.expand_start) begin
            for (int n = 0; n < 4; n++) begin
               if (((4 * w + n) < int'(key_length)) && ((4 * w + n) < MAX_KEY_BYTES)) begin
                  kw_in[w][8*n +: 8] = key_bits[8*(4*w+n) +: 8];
               end else begin
                  kw_in[w][8*n +: 8] = 8'h00;
               end
            end
         end
      end
      if (cmd.mix_b) begin
         kw_in[key_idx] = b_mix;
      end
   end

   // Result register; it parts the result channel from the working words.
   always_comb begin
      out_block_in  = out_block_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         case (cmd.out_kind)
            RES_CIPHER: begin
               out_block_in  = {b_ff, a_ff};
               out_status_in = 1'b0;
            end
            RES_ERROR: begin
               out_block_in  = '0;
               out_status_in = 1'b1;
            end
            default: begin
               out_block_in  = '0;
               out_status_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      kw_ff         <= kw_in;
      out_block_ff  <= out_block_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.out_busy = out_valid_ff && !rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_block_ff;
   assign rsp_tuser       = out_status_ff;

endmodule

`default_nettype wire

// File: hdl/rc5_ctrl.sv
`default_nettype none

module rc5_ctrl #(
   parameter int unsigned MAX_ROUNDS    = 32,
   parameter int unsigned MAX_KEY_BYTES = 32,
   parameter int unsigned AW            = 7,
   parameter int unsigned KW_AW         = 3
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [rc5_pkg::MODE_W-1:0] req_mode,
   input  wire logic [rc5_pkg::CFG_W-1:0]  key_length,
   input  wire logic [rc5_pkg::CFG_W-1:0]  round_count,
   input  wire rc5_pkg::dp_status_type     status,
   output rc5_pkg::ctrl_cmd_type           cmd,
   output logic                            mem_we,
   output logic      [AW-1:0]              wr_addr,
   output logic      [AW-1:0]              rd_addr,
   output logic      [KW_AW-1:0]           key_idx
);

   import rc5_pkg::*;

   localparam int unsigned RW       = $clog2(MAX_ROUNDS + 1);
   localparam int unsigned DEPTH    = 2 * (MAX_ROUNDS + 1);
   localparam int unsigned KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
   localparam int unsigned MIXMAX   = (DEPTH > KEY_WORDS) ? DEPTH : KEY_WORDS;
   localparam int unsigned NW       = $clog2(3 * MIXMAX);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_INIT    = 8'b0000_0010,
      ST_MIX_RD  = 8'b0000_0100,
      ST_MIX_A   = 8'b0000_1000,
      ST_MIX_B   = 8'b0001_0000,
      ST_CIPH_RD = 8'b0010_0000,
      ST_CIPH    = 8'b0100_0000,
      ST_FINISH  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [KW_AW-1:0]  kidx_ff, kidx_in;
   logic [NW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     t_last_ff, t_last_in;
   logic [KW_AW-1:0]  c_last_ff, c_last_in;
   logic              ready_ff, ready_in;
   logic              decrypt_ff, decrypt_in;
   result_type        kind_ff, kind_in;

   logic [RW-1:0]     r_sat;
   logic [CFG_W-1:0]  len_sat;
   logic [CFG_W:0]    len_round;
   logic [4:0]        c_words;
   logic [NW-1:0]     t_cnt;
   logic [NW-1:0]     c_cnt;
   logic [NW-1:0]     mx_cnt;
   logic [NW-1:0]     mix_last;
   logic [AW-1:0]     mix_next;
   logic [AW-1:0]     ciph_next;
   mode_type          mode;

   // Schedule sizes from the configuration, saturated to the build limits.
   always_comb begin
      r_sat     = (round_count > MAX_ROUNDS) ? RW'(MAX_ROUNDS) : RW'(round_count);
      len_sat   = (key_length > MAX_KEY_BYTES) ? CFG_W'(MAX_KEY_BYTES) : key_length;
      len_round = {1'b0, len_sat} + (CFG_W+1)'(3);
      c_words   = len_round[CFG_W:2];
      t_last_in = AW'({r_sat, 1'b1});
      c_last_in = (c_words == 5'd0) ? '0 : KW_AW'(c_words - 5'd1);
      t_cnt     = (NW'(r_sat) << 1) + NW'(2);
      c_cnt     = (c_words == 5'd0) ? NW'(1) : NW'(c_words);
      mx_cnt    = (t_cnt > c_cnt) ? t_cnt : c_cnt;
      mix_last  = (mx_cnt << 1) + mx_cnt - NW'(1);
      mode      = mode_type'(req_mode);
   end

   // Next subkey indexes: wrapping for mixing, up or down for the cipher.
   always_comb begin
      mix_next  = (addr_ff == t_last_ff) ? '0 : addr_ff + AW'(1);
      ciph_next = decrypt_ff ? addr_ff - AW'(1) : addr_ff + AW'(1);
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      kidx_in    = kidx_ff;
      cnt_in     = cnt_ff;
      ready_in   = ready_ff;
      decrypt_in = decrypt_ff;
      kind_in    = kind_ff;
      cmd        = '0;
      cmd.out_kind     = kind_ff;
      cmd.step_b       = addr_ff[0];
      cmd.step_white   = (addr_ff[AW-1:1] == '0);
      cmd.step_decrypt = decrypt_ff;
      mem_we     = 1'b0;
      rd_addr    = addr_ff;
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (mode)
                  MODE_EXPAND: begin
                     cmd.expand_start = 1'b1;
                     addr_in  = '0;
                     kidx_in  = '0;
                     cnt_in   = mix_last;
                     ready_in = 1'b1;
                     kind_in  = RES_ZERO;
                     state_in = ST_INIT;
                  end
                  MODE_ENCRYPT, MODE_DECRYPT: begin
                     if (ready_ff) begin
                        cmd.cipher_start = 1'b1;
                        decrypt_in = (mode == MODE_DECRYPT);
                        addr_in    = (mode == MODE_DECRYPT) ? t_last_ff : '0;
                        cnt_in     = NW'(t_last_ff);
                        kind_in    = RES_CIPHER;
                        state_in   = ST_CIPH_RD;
                     end else begin
                        kind_in  = RES_ERROR;
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     kind_in  = RES_ZERO;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_write = 1'b1;
            mem_we = 1'b1;
            if (addr_ff == t_last_ff) begin
               addr_in  = '0;
               state_in = ST_MIX_RD;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_MIX_RD: begin
            state_in = ST_MIX_A;
         end
         ST_MIX_A: begin
            cmd.mix_a = 1'b1;
            mem_we    = 1'b1;
            state_in  = ST_MIX_B;
         end
         ST_MIX_B: begin
            cmd.mix_b = 1'b1;
            rd_addr   = mix_next;
            addr_in   = mix_next;
            kidx_in   = (kidx_ff == c_last_ff) ? '0 : kidx_ff + KW_AW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in   = cnt_ff - NW'(1);
               state_in = ST_MIX_A;
            end
         end
         ST_CIPH_RD: begin
            state_in = ST_CIPH;
         end
         ST_CIPH: begin
            cmd.cipher_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               rd_addr  = ciph_next;
               addr_in  = ciph_next;
               cnt_in   = cnt_ff - NW'(1);
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ready_ff   <= 1'b0;
         kind_ff    <= RES_ZERO;
         decrypt_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ready_ff   <= ready_in;
         kind_ff    <= kind_in;
         decrypt_ff <= decrypt_in;
      end
   end

   // Schedule sizes are latched when an expansion starts.
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      kidx_ff <= kidx_in;
      cnt_ff  <= cnt_in;
      if (cmd.expand_start) begin
         t_last_ff <= t_last_in;
         c_last_ff <= c_last_in;
      end
   end

   assign wr_addr = addr_ff;
   assign key_idx = kidx_ff;

endmodule

`default_nettype wire

// File: hdl/rc5_32_block_cipher.sv
// RC5-32 block cipher with a configurable round count and key length.
//
// Configuration: a 64-bit APB-style port. Registers at byte address 8*i:
// key bytes 0-7, 8-15, 16-23, 24-31, key length, round count. Write only
// while the block is idle.
// Requests: req_tuser carries the mode (expand, encrypt, decrypt), req_tdata
// the block, word A in the low half. Each request gives exactly one result
// on the rsp channel: the block and a status bit.
// An expand request builds the 2*(r+1) subkeys in a table with one write
// port and one registered read port: a fill pass over the table, then
// 3*max(t,c) mixing steps, each a subkey half and then a key word half.
// Encrypt and decrypt take one subkey per cycle from the table's read port,
// one half-round per cycle; a new block is taken only once the previous
// result has been loaded into the output register.
// A block request before any expansion, or an unused mode, goes straight to
// the finish state and answers from there. Reset clears the schedule-valid
// flag and the result valid flag; the subkey table needs no clearing. If
// the receiver stalls, the finished result waits in the output register and
// the next request is taken, but its result waits until the register is free.
`default_nettype none

module rc5_32_block_cipher #(
   parameter int unsigned MAX_ROUNDS    = rc5_pkg::DEF_MAX_ROUNDS,
   parameter int unsigned MAX_KEY_BYTES = rc5_pkg::DEF_MAX_KEY_BYTES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Configuration port.
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rc5_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [rc5_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [rc5_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready,
   // Request channel.
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [rc5_pkg::BLOCK_W-1:0] req_tdata,  // [63:0] block_in
   input  wire logic [rc5_pkg::MODE_W-1:0]  req_tuser,  // [1:0] mode
   // Result channel.
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [rc5_pkg::BLOCK_W-1:0] rsp_tdata,  // [63:0] block_out
   output logic      [0:0]                  rsp_tuser   // [0] status
);

   import rc5_pkg::*;

   localparam int unsigned DEPTH     = 2 * (MAX_ROUNDS + 1);
   localparam int unsigned AW        = $clog2(DEPTH);
   localparam int unsigned KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
   localparam int unsigned KW_AW     = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

   logic [CSR_DW-1:0] key_ff [4];
   logic [CSR_DW-1:0] key_in [4];
   logic [CFG_W-1:0]  key_length_ff, key_length_in;
   logic [CFG_W-1:0]  round_count_ff, round_count_in;

   logic              csr_write;
   logic [2:0]        csr_index;
   ctrl_cmd_type      ctrl_cmd;
   dp_status_type     dp_status;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rdata;
   logic [KW_AW-1:0]  key_idx;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];

   always_comb begin
      key_in         = key_ff;
      key_length_in  = key_length_ff;
      round_count_in = round_count_ff;
      if (csr_write) begin
         case (csr_index)
            REG_KEY0:   key_in[0]      = csr_pwdata;
            REG_KEY1:   key_in[1]      = csr_pwdata;
            REG_KEY2:   key_in[2]      = csr_pwdata;
            REG_KEY3:   key_in[3]      = csr_pwdata;
            REG_KEYLEN: key_length_in  = csr_pwdata[CFG_W-1:0];
            REG_ROUNDS: round_count_in = csr_pwdata[CFG_W-1:0];
            default:    key_length_in  = key_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff         <= '{default: '0};
         key_length_ff  <= CFG_W'(16);
         round_count_ff <= CFG_W'(12);
      end else begin
         key_ff         <= key_in;
         key_length_ff  <= key_length_in;
         round_count_ff <= round_count_in;
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         REG_KEY0:   csr_prdata = key_ff[0];
         REG_KEY1:   csr_prdata = key_ff[1];
         REG_KEY2:   csr_prdata = key_ff[2];
         REG_KEY3:   csr_prdata = key_ff[3];
         REG_KEYLEN: csr_prdata = CSR_DW'(key_length_ff);
         REG_ROUNDS: csr_prdata = CSR_DW'(round_count_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Sequencer.
   rc5_ctrl #(
      .MAX_ROUNDS    (MAX_ROUNDS),
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .AW            (AW),
      .KW_AW         (KW_AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tuser),
      .key_length  (key_length_ff),
      .round_count (round_count_ff),
      .status      (dp_status),
      .cmd         (ctrl_cmd),
      .mem_we      (mem_we),
      .wr_addr     (mem_waddr),
      .rd_addr     (mem_raddr),
      .key_idx     (key_idx)
   );

   // Subkey table.
   rc5_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_subkey_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Working words, key words and the result register.
   rc5_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .KW_AW         (KW_AW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .status     (dp_status),
      .key_idx    (key_idx),
      .key_bits   ({key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .key_length (key_length_ff),
      .block_in   (req_tdata),
      .rd_data    (mem_rdata),
      .wr_data    (mem_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A transfer on the request side always starts work.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a request was in work");

   // An error result never carries a block.
   a_error_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("error result with nonzero block");

   // A result shows up only when the sequencer loads it.
   a_result_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl_cmd.out_load))
      else $error("result appeared without a load");

   // The subkey table is written only while a request is in work.
   a_table_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !req_tready)
      else $error("subkey table written while idle");

endmodule

`default_nettype wire

// File: tb/rc5_32_block_cipher_test.sv
`timescale 1ns / 1ps

module rc5_32_block_cipher_test;
   import rc5_pkg::*;

   localparam int unsigned LIMIT_ROUNDS    = DEF_MAX_ROUNDS;
   localparam int unsigned LIMIT_KEY_BYTES = DEF_MAX_KEY_BYTES;
   localparam int unsigned SUBKEY_COUNT    = 2 * (LIMIT_ROUNDS + 1);
   localparam int unsigned KEY_WORD_COUNT  = (LIMIT_KEY_BYTES + 3) / 4;
   localparam logic [31:0] SEED_P = 32'hB7E1_5163;
   localparam logic [31:0] STEP_Q = 32'h9E37_79B9;
   localparam int unsigned RANDOM_PHASES    = 8;
   localparam int unsigned ITEMS_PER_PHASE  = 65;
   localparam int unsigned PRESSURE_AFTER   = 150;
   localparam int unsigned PRESSURE_CYCLES  = 400;

   localparam logic [2:0] KEY_REG_INDEX [4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

   typedef struct packed {
      logic [63:0] data;
      logic        status;
   } cipher_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One step of the directed sequence: either a request or a register write.
   // For requests with known = 1 the expected result is given in the row.
   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   reg_index;
      mode_type     mode;
      logic [63:0]  data;
      logic         known;
      logic [63:0]  want_data;
      logic         want_status;
   } step_row_type;

   localparam int unsigned STEP_COUNT = 35;
   localparam step_row_type DIRECTED_STEPS [STEP_COUNT] = '{
      // Block requests before any key schedule, and the unused mode.
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'h0,                  1'b1, 64'h0, 1'b1},
      '{ROW_ITEM, REG_KEY0,   MODE_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b1},
      '{ROW_ITEM, REG_KEY0,   MODE_UNUSED,  64'h0123_4567_89AB_CDEF, 1'b1, 64'h0, 1'b0},
      // Default key (sixteen zero bytes, twelve rounds).
      '{ROW_ITEM, REG_KEY0,   MODE_EXPAND,  64'hFEDC_BA98_7654_3210, 1'b1, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'h0,                  1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'h8000_0000_0000_0001, 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b0},
      // Full 32-byte key with zero rounds: whitening only.
      '{ROW_CSR,  REG_KEY0,   MODE_EXPAND,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_KEY1,   MODE_EXPAND,  64'h0123_4567_89AB_CDEF, 1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_KEY2,   MODE_EXPAND,  64'h0,                  1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_KEY3,   MODE_EXPAND,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_KEYLEN, MODE_EXPAND,  64'd32,                 1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_ROUNDS, MODE_EXPAND,  64'd0,                  1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_EXPAND,  64'h0,                  1'b1, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'h5555_5555_5555_5555, 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0, 1'b0},
      // Oversized key length and round count saturate.
      '{ROW_CSR,  REG_KEYLEN, MODE_EXPAND,  64'd63,                 1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_ROUNDS, MODE_EXPAND,  64'd63,                 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_EXPAND,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_DECRYPT, 64'h0,                  1'b0, 64'h0, 1'b0},
      // Empty key: one zero key word; single round.
      '{ROW_CSR,  REG_KEYLEN, MODE_EXPAND,  64'd0,                  1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_ROUNDS, MODE_EXPAND,  64'd1,                  1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_EXPAND,  64'h0,                  1'b1, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'h0000_0001_8000_0000, 1'b0, 64'h0, 1'b0},
      // Registers changed without a new expansion keep the old schedule.
      '{ROW_CSR,  REG_ROUNDS, MODE_EXPAND,  64'd20,                 1'b0, 64'h0, 1'b0},
      '{ROW_CSR,  REG_KEYLEN, MODE_EXPAND,  64'd5,                  1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_DECRYPT, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_EXPAND,  64'h0,                  1'b1, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_DECRYPT, 64'h1234_5678_9ABC_DEF0, 1'b0, 64'h0, 1'b0},
      // Largest round count.
      '{ROW_CSR,  REG_ROUNDS, MODE_EXPAND,  64'd32,                 1'b0, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_EXPAND,  64'h0,                  1'b1, 64'h0, 1'b0},
      '{ROW_ITEM, REG_KEY0,   MODE_ENCRYPT, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0, 64'h0, 1'b0}
   };

   logic                clock;
   logic                reset       = 1'b1;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [BLOCK_W-1:0]  req_tdata   = '0;  // [63:0] block_in
   logic [MODE_W-1:0]   req_tuser   = '0;  // [1:0] mode
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [BLOCK_W-1:0]  rsp_tdata;         // [63:0] block_out
   logic [0:0]          rsp_tuser;         // [0] status

   // Shadow of the configuration and of the key schedule state.
   logic [63:0] key_shadow [4];
   logic [5:0]  keylen_shadow = 6'd16;
   logic [5:0]  rounds_shadow = 6'd12;
   logic [31:0] subkeys [SUBKEY_COUNT];
   logic [31:0] key_words [KEY_WORD_COUNT];
   logic        keyed = 1'b0;
   int unsigned keyed_rounds = 0;

   cipher_result_type pending_results [$];
   int unsigned       results_seen = 0;
   int unsigned       error_count  = 0;
   logic              sender_burst = 1'b0;

   rc5_32_block_cipher u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("rc5_32_block_cipher_test: done, errors");
      $finish;
   end

   function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
      return (x << n) | (x >> (6'd32 - n));
   endfunction

   function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [4:0] n);
      return (x >> n) | (x << (6'd32 - n));
   endfunction

   // Build the subkey table from the shadow key with the three-pass mix.
   function automatic void expand_subkeys();
      int unsigned rounds, key_len, t, c, steps, i, j, k;
      logic [31:0] a, b;
      rounds  = (rounds_shadow > LIMIT_ROUNDS) ? LIMIT_ROUNDS : rounds_shadow;
      key_len = (keylen_shadow > LIMIT_KEY_BYTES) ? LIMIT_KEY_BYTES : keylen_shadow;
      t = 2 * (rounds + 1);
      c = (key_len + 3) / 4;
      if (c == 0) c = 1;
      for (k = 0; k < KEY_WORD_COUNT; k++) key_words[k] = '0;
      for (k = 0; k < key_len; k++) begin
         key_words[k / 4] |= 32'(key_shadow[k / 8][(k % 8) * 8 +: 8]) << ((k % 4) * 8);
      end
      subkeys[0] = SEED_P;
      for (k = 1; k < t; k++) subkeys[k] = subkeys[k - 1] + STEP_Q;
      steps = 3 * ((t > c) ? t : c);
      a = '0;
      b = '0;
      i = 0;
      j = 0;
      for (k = 0; k < steps; k++) begin
         a = rot_left(subkeys[i] + a + b, 5'd3);
         subkeys[i] = a;
         b = rot_left(key_words[j] + a + b, a[4:0] + b[4:0]);
         key_words[j] = b;
         i = (i + 1 == t) ? 0 : i + 1;
         j = (j + 1 == c) ? 0 : j + 1;
      end
      keyed_rounds = rounds;
      keyed = 1'b1;
   endfunction

   // Work out the result of one request and update the schedule state.
   function automatic cipher_result_type predict_cipher(input mode_type mode,
                                                        input logic [63:0] blk);
      cipher_result_type res;
      logic [31:0] a, b;
      int unsigned r;
      res.data   = '0;
      res.status = 1'b0;
      a = blk[31:0];
      b = blk[63:32];
      if (mode == MODE_EXPAND) begin
         expand_subkeys();
      end else if (mode != MODE_UNUSED) begin
         if (!keyed) begin
            res.status = 1'b1;
         end else if (mode == MODE_ENCRYPT) begin
            a = a + subkeys[0];
            b = b + subkeys[1];
            for (r = 1; r <= keyed_rounds; r++) begin
               a = rot_left(a ^ b, b[4:0]) + subkeys[2 * r];
               b = rot_left(b ^ a, a[4:0]) + subkeys[2 * r + 1];
            end
            res.data = {b, a};
         end else begin
            for (r = keyed_rounds; r >= 1; r--) begin
               b = rot_right(b - subkeys[2 * r + 1], a[4:0]) ^ a;
               a = rot_right(a - subkeys[2 * r], b[4:0]) ^ b;
            end
            b = b - subkeys[1];
            a = a - subkeys[0];
            res.data = {b, a};
         end
      end
      return res;
   endfunction

   // Register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_KEYLEN: keylen_shadow = value[5:0];
         REG_ROUNDS: rounds_shadow = value[5:0];
         default:    key_shadow[index[1:0]] = value;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one request and record its expected result once it is taken.
   task automatic send_request(input mode_type mode, input logic [63:0] blk,
                               input logic known, input cipher_result_type typed);
      cipher_result_type guess;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= blk;
      do @(posedge clock); while (!req_tready);
      guess = predict_cipher(mode, blk);
      if (known) guess = typed;
      pending_results = {pending_results, guess};
   endtask

   task automatic pause_requests(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Stop offering and let every outstanding result come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (sender_burst || roll < 60) return 0;
      else if (roll < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] pick_block();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      else if (roll == 1) return '1;
      else return {$urandom, $urandom};
   endfunction

   function automatic logic [5:0] pick_rounds();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 6'($urandom_range(0, 12));
      else if (roll < 80) return 6'(LIMIT_ROUNDS);
      else if (roll < 90) return 6'($urandom_range(LIMIT_ROUNDS + 1, 63));
      else return 6'($urandom_range(13, LIMIT_ROUNDS - 1));
   endfunction

   function automatic logic [5:0] pick_key_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 6'($urandom_range(0, LIMIT_KEY_BYTES));
      else if (roll < 85) return 6'(LIMIT_KEY_BYTES);
      else return 6'($urandom_range(LIMIT_KEY_BYTES + 1, 63));
   endfunction

   // Main stimulus: directed steps, then random phases with fresh settings.
   initial begin : stimulus
      cipher_result_type typed;
      mode_type          mode;
      int unsigned       roll;
      for (int k = 0; k < 4; k++) key_shadow[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < STEP_COUNT; n++) begin
         if (DIRECTED_STEPS[n].kind == ROW_CSR) begin
            drain_results();
            csr_write(DIRECTED_STEPS[n].reg_index, DIRECTED_STEPS[n].data);
         end else begin
            typed.data   = DIRECTED_STEPS[n].want_data;
            typed.status = DIRECTED_STEPS[n].want_status;
            send_request(DIRECTED_STEPS[n].mode, DIRECTED_STEPS[n].data,
                         DIRECTED_STEPS[n].known, typed);
            pause_requests(pick_gap());
         end
      end

      typed = '0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_results();
         csr_write(REG_ROUNDS, 64'(pick_rounds()));
         if ($urandom_range(0, 1) == 0) csr_write(REG_KEYLEN, 64'(pick_key_length()));
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 1) == 0) csr_write(KEY_REG_INDEX[k], {$urandom, $urandom});
         end
         sender_burst = ($urandom_range(0, 3) == 0);
         // Most phases key up first; the others run on the previous schedule.
         if ($urandom_range(0, 4) != 0) begin
            send_request(MODE_EXPAND, pick_block(), 1'b0, typed);
            pause_requests(pick_gap());
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) mode = MODE_EXPAND;
            else if (roll < 5) mode = MODE_UNUSED;
            else if (roll < 52) mode = MODE_ENCRYPT;
            else mode = MODE_DECRYPT;
            send_request(mode, pick_block(), 1'b0, typed);
            pause_requests(pick_gap());
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (error_count == 0) begin
         $display("rc5_32_block_cipher_test: done, clean");
      end else begin
         $display("rc5_32_block_cipher_test: done, errors");
      end
      $finish;
   end

   // Receiver: short random stalls, calm stretches, and one long hold-off.
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned roll;
      logic        pressure_done;
      stall_left    = 0;
      calm_left     = 0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            stall_left    = PRESSURE_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 3) calm_left = $urandom_range(50, 200);
               else if (roll < 20) stall_left = $urandom_range(1, 3);
               else if (roll < 23) stall_left = $urandom_range(10, 60);
            end
         end
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      cipher_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            error_count++;
            $error("unexpected result: block_out %h status %b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.data) begin
               error_count++;
               $error("block_out: expected %h, actual %h", want.data, rsp_tdata);
            end
            if (rsp_tuser[0] !== want.status) begin
               error_count++;
               $error("status: expected %b, actual %b", want.status, rsp_tuser[0]);
            end
         end
      end
   end

endmodule

// File: rc5_32_block_cipher.f
hdl/rc5_pkg.sv
hdl/rc5_ram.sv
hdl/rc5_datapath.sv
hdl/rc5_ctrl.sv
hdl/rc5_32_block_cipher.sv
tb/rc5_32_block_cipher_test.sv
